>>> hdl/dibpm_pkg.sv
// ----------------------------------------------------------------------------
// dibpm_pkg
// shared constants and codes of the dual receiver block power meter
// ----------------------------------------------------------------------------
`default_nettype none

package dibpm_pkg;

	// default parameter values
	localparam int MAX_SAMPLES_DEF     = 65536;
	localparam int SAMPLE_BITS_DEF     = 16;
	localparam int LEVEL_FRAC_BITS_DEF = 8;

	// field widths
	localparam int FIELD_W = 16;
	localparam int LEVEL_W = 17;
	localparam int THR_W   = 17;
	localparam int CFG_W   = 17;
	localparam int IDX_W   = 2;
	localparam int IN_W    = 4 * FIELD_W;
	localparam int OUT_W   = 56;

	// log arithmetic
	localparam int LOG_FRAC        = 24;
	localparam int TEN_LOG10_2_Q24 = 50504453;
	localparam int FLOOR_DB        = 200;
	localparam int SUM_W           = 48;

	// register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_DUAL_ENABLE  = 2'd0,
		REG_COMBINE_MODE = 2'd1,
		REG_THRESHOLD    = 2'd2,
		REG_NONE         = 2'd3
	} reg_idx_t;

	// combine modes
	localparam logic [1:0] MODE_MAX      = 2'd0;
	localparam logic [1:0] MODE_AVERAGE  = 2'd1;
	localparam logic [1:0] MODE_SEPARATE = 2'd2;

endpackage

`default_nettype wire

>>> hdl/dual_iq_block_power_meter.sv
// ----------------------------------------------------------------------------
// dual_iq_block_power_meter
// block mean power of one or two i/q receivers, reported in dBFS
// ----------------------------------------------------------------------------
//  channel  direction  handshake          contents
//  s_*      in         tvalid/tready      rx1 i, rx1 q, rx2 i, rx2 q; tlast ends block
//  m_*      out        tvalid/tready      rx1, rx2, combined level, active, rx2 valid,
//                                         overflow
//  cfg_*    in         cfg_wr_en          dual enable, combine mode, threshold
//
//  a word is squared, then accumulated; ready is high only in idle
//  a closing word then runs the level unit: per level a bit-serial leading-one
//  search and 24 squaring steps (square, update), for the sum and for the count,
//  then scaling and rounding; up to three levels (rx1, rx2, average)
//  the result waits in an output register; a new block may start meanwhile
//  reset clears control state, sums, tally and registers
// ----------------------------------------------------------------------------
`default_nettype none

module dual_iq_block_power_meter #(
	parameter int MAX_SAMPLES     = dibpm_pkg::MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS     = dibpm_pkg::SAMPLE_BITS_DEF,
	parameter int LEVEL_FRAC_BITS = dibpm_pkg::LEVEL_FRAC_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// rx1 i, rx1 q, rx2 i, rx2 q (16 bit each)
	input  wire logic [dibpm_pkg::IN_W-1:0]  s_tdata,
	input  wire logic                        s_tlast,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	// rx1 level, rx2 level, combined level (17 bit each), active, rx2 valid,
	// overflow, two zero bits
	output logic [dibpm_pkg::OUT_W-1:0]      m_tdata,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	input  wire logic                        cfg_wr_en,
	input  wire logic [dibpm_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [dibpm_pkg::CFG_W-1:0] cfg_wdata
);
	import dibpm_pkg::*;

	localparam int SB     = SAMPLE_BITS;
	localparam int F      = LEVEL_FRAC_BITS;
	localparam int SQ_W   = 2 * SB;
	localparam int TW     = $clog2(MAX_SAMPLES + 1);
	localparam int NW     = SUM_W + 1;
	localparam int EW     = $clog2(NW);
	localparam int LVL_W  = F + 9;
	localparam int CMP_W  = (LVL_W > THR_W) ? LVL_W : THR_W;
	localparam int M_W    = 31;
	localparam int P_W    = 2 * M_W;
	localparam int SHIFT  = 2 * LOG_FRAC - F;
	localparam logic signed [31:0] OFFSET = 32'((2 * SB - 1) << LOG_FRAC);
	localparam logic [P_W:0] HALF = (P_W+1)'(1) << (SHIFT - 1);
	localparam logic [P_W:0] FLOOR_MAG = (P_W+1)'(FLOOR_DB) << F;
	localparam logic signed [LVL_W-1:0] FLOOR_LVL = -LVL_W'(FLOOR_DB << F);
	localparam logic [SUM_W:0] SUM_MAX = {1'b0, {SUM_W{1'b1}}};

	typedef enum logic [3:0] {
		ST_IDLE, ST_SQR, ST_ACC, ST_PICK, ST_NRM, ST_LSQ, ST_LUPD,
		ST_CHK, ST_MULC, ST_RND, ST_FIN
	} state_t;

	typedef enum logic [1:0] {JOB_RX1, JOB_RX2, JOB_AVG} job_t;

	state_t state_q;
	job_t   job_q;

	// configuration
	logic                    dual_q;
	logic [1:0]              mode_q;
	logic signed [THR_W-1:0] thr_q;

	// accumulation
	logic signed [SB-1:0] i1_q, q1_q, i2_q, q2_q;
	logic                 last_q;
	logic [SQ_W-1:0]      i1sq_q, q1sq_q, i2sq_q, q2sq_q;
	logic [SUM_W-1:0]     sum1_q, sum2_q;
	logic [TW-1:0]        tally_q;
	logic                 ovf_q;

	// level unit
	logic [NW-1:0]           x_q;
	logic [EW-1:0]           e_q;
	logic [M_W-1:0]          m_q;
	logic signed [31:0]      r_q, lsum_q, diff_q;
	logic [4:0]              bit_q;
	logic                    phase_q;
	logic [P_W-1:0]          prod_q;
	logic signed [LVL_W-1:0] l1_q, l2_q, lc_q;

	// combinational helpers
	logic [NW-1:0]           sel_sum, sel_cnt;
	logic [M_W-1:0]          mul_a, mul_b;
	logic [2*M_W-1:0]        mul_p;
	logic [31:0]             sq_t;
	logic signed [31:0]      r_nxt;
	logic [P_W:0]            rnd;
	logic signed [LVL_W-1:0] rnd_lvl, fin_l2, fin_lc;
	logic [SQ_W:0]           e1, e2;
	logic [SUM_W:0]          add1, add2;
	logic                    out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid || m_tready;

	// operand select for the level of the current job
	always_comb begin
		sel_sum = NW'(sum1_q);
		sel_cnt = NW'(tally_q);
		case (job_q)
			JOB_RX2: sel_sum = NW'(sum2_q);
			JOB_AVG: begin
				sel_sum = NW'(sum1_q) + NW'(sum2_q);
				sel_cnt = NW'({tally_q, 1'b0});
			end
			default: sel_sum = NW'(sum1_q);
		endcase
	end

	// shared multiplier: mantissa squaring or scaling by 10*log10(2)
	always_comb begin
		if (state_q == ST_LSQ) begin
			mul_a = m_q;
			mul_b = m_q;
		end else begin
			mul_a = M_W'(-diff_q);
			mul_b = M_W'(TEN_LOG10_2_Q24);
		end
		mul_p = mul_a * mul_b;
	end

	// squaring step update
	always_comb begin
		sq_t  = prod_q[61:30];
		r_nxt = r_q;
		if (sq_t[31])
			r_nxt = r_q + (32'sd1 <<< bit_q);
	end

	// rounding of the scaled magnitude
	always_comb begin
		rnd = ((P_W+1)'(prod_q) + HALF) >> SHIFT;
		if (rnd > FLOOR_MAG)
			rnd_lvl = FLOOR_LVL;
		else
			rnd_lvl = -LVL_W'(rnd);
	end

	// energy adds with saturation
	always_comb begin
		e1   = (SQ_W+1)'(i1sq_q) + (SQ_W+1)'(q1sq_q);
		e2   = (SQ_W+1)'(i2sq_q) + (SQ_W+1)'(q2sq_q);
		add1 = (SUM_W+1)'(sum1_q) + (SUM_W+1)'(e1);
		add2 = (SUM_W+1)'(sum2_q) + (SUM_W+1)'(e2);
	end

	// combining of the finished levels
	always_comb begin
		fin_l2 = l2_q;
		fin_lc = l1_q;
		if (!dual_q) begin
			fin_l2 = FLOOR_LVL;
		end else begin
			case (mode_q)
				MODE_MAX, MODE_SEPARATE: fin_lc = (l1_q > l2_q) ? l1_q : l2_q;
				MODE_AVERAGE:            fin_lc = lc_q;
				default:                 fin_lc = l1_q;
			endcase
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dual_q <= 1'b0;
			mode_q <= MODE_MAX;
			thr_q  <= -THR_W'(14080);
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DUAL_ENABLE:  dual_q <= cfg_wdata[0];
				REG_COMBINE_MODE: mode_q <= cfg_wdata[1:0];
				REG_THRESHOLD:    thr_q  <= cfg_wdata[THR_W-1:0];
				default:          ;
			endcase
		end
	end

	// sequencer, accumulators and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			job_q    <= JOB_RX1;
			sum1_q   <= '0;
			sum2_q   <= '0;
			tally_q  <= '0;
			ovf_q    <= 1'b0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			i1_q <= '0; q1_q <= '0; i2_q <= '0; q2_q <= '0;
			last_q <= 1'b0;
			i1sq_q <= '0; q1sq_q <= '0; i2sq_q <= '0; q2sq_q <= '0;
			x_q <= '0; e_q <= '0; m_q <= '0; r_q <= '0; lsum_q <= '0;
			diff_q <= '0; bit_q <= '0; phase_q <= 1'b0; prod_q <= '0;
			l1_q <= '0; l2_q <= '0; lc_q <= '0;
		end else begin
			if (m_tvalid && m_tready && state_q != ST_FIN)
				m_tvalid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						i1_q    <= s_tdata[SB-1:0];
						q1_q    <= s_tdata[FIELD_W +: SB];
						i2_q    <= s_tdata[2*FIELD_W +: SB];
						q2_q    <= s_tdata[3*FIELD_W +: SB];
						last_q  <= s_tlast;
						state_q <= ST_SQR;
					end
				end
				// squares of the four samples
				ST_SQR: begin
					i1sq_q  <= SQ_W'(i1_q) * SQ_W'(i1_q);
					q1sq_q  <= SQ_W'(q1_q) * SQ_W'(q1_q);
					i2sq_q  <= SQ_W'(i2_q) * SQ_W'(i2_q);
					q2sq_q  <= SQ_W'(q2_q) * SQ_W'(q2_q);
					state_q <= ST_ACC;
				end
				// saturating accumulate, drop past the block limit
				ST_ACC: begin
					if (tally_q < TW'(MAX_SAMPLES)) begin
						sum1_q  <= (add1 > SUM_MAX) ? SUM_W'(SUM_MAX) : SUM_W'(add1);
						sum2_q  <= (add2 > SUM_MAX) ? SUM_W'(SUM_MAX) : SUM_W'(add2);
						if (add1 > SUM_MAX || add2 > SUM_MAX)
							ovf_q <= 1'b1;
						tally_q <= tally_q + TW'(1);
					end else begin
						ovf_q <= 1'b1;
					end
					job_q   <= JOB_RX1;
					state_q <= last_q ? ST_PICK : ST_IDLE;
				end
				// start a level, or floor it on zero power
				ST_PICK: begin
					if (sel_sum == '0 || sel_cnt == '0) begin
						unique case (job_q)
							JOB_RX1: l1_q <= FLOOR_LVL;
							JOB_RX2: l2_q <= FLOOR_LVL;
							default: lc_q <= FLOOR_LVL;
						endcase
						state_q <= ST_CHK;
						diff_q  <= 32'sd0;
					end else begin
						x_q     <= sel_sum;
						e_q     <= EW'(NW - 1);
						phase_q <= 1'b0;
						state_q <= ST_NRM;
					end
				end
				// leading-one search, one bit per cycle
				ST_NRM: begin
					if (x_q[NW-1]) begin
						m_q     <= x_q[NW-1 -: M_W];
						r_q     <= 32'(e_q) <<< LOG_FRAC;
						bit_q   <= 5'(LOG_FRAC - 1);
						state_q <= ST_LSQ;
					end else begin
						x_q <= x_q << 1;
						e_q <= e_q - EW'(1);
					end
				end
				ST_LSQ: begin
					prod_q  <= mul_p;
					state_q <= ST_LUPD;
				end
				// one fraction bit of log2
				ST_LUPD: begin
					m_q <= sq_t[31] ? M_W'(sq_t >> 1) : M_W'(sq_t);
					r_q <= r_nxt;
					if (bit_q == '0) begin
						if (!phase_q) begin
							lsum_q  <= r_nxt;
							phase_q <= 1'b1;
							x_q     <= sel_cnt;
							e_q     <= EW'(NW - 1);
							state_q <= ST_NRM;
						end else begin
							diff_q  <= lsum_q - r_nxt - OFFSET;
							state_q <= ST_MULC;
						end
					end else begin
						bit_q   <= bit_q - 5'd1;
						state_q <= ST_LSQ;
					end
				end
				// full scale clips at zero, else scale by 10*log10(2)
				ST_MULC: begin
					if (diff_q >= 0) begin
						unique case (job_q)
							JOB_RX1: l1_q <= '0;
							JOB_RX2: l2_q <= '0;
							default: lc_q <= '0;
						endcase
						state_q <= ST_CHK;
					end else begin
						prod_q  <= mul_p;
						state_q <= ST_RND;
					end
				end
				ST_RND: begin
					unique case (job_q)
						JOB_RX1: l1_q <= rnd_lvl;
						JOB_RX2: l2_q <= rnd_lvl;
						default: lc_q <= rnd_lvl;
					endcase
					state_q <= ST_CHK;
				end
				// next level job
				ST_CHK: begin
					if (job_q == JOB_RX1 && dual_q) begin
						job_q   <= JOB_RX2;
						state_q <= ST_PICK;
					end else if (job_q == JOB_RX2 && mode_q == MODE_AVERAGE) begin
						job_q   <= JOB_AVG;
						state_q <= ST_PICK;
					end else begin
						state_q <= ST_FIN;
					end
				end
				// hand the word over and open a new block
				ST_FIN: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {2'b00, ovf_q, dual_q,
							CMP_W'(fin_lc) >= CMP_W'(thr_q),
							LEVEL_W'(fin_lc), LEVEL_W'(fin_l2), LEVEL_W'(l1_q)};
						sum1_q   <= '0;
						sum2_q   <= '0;
						tally_q  <= '0;
						ovf_q    <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hdl/dibpm_checker.sv
// ----------------------------------------------------------------------------
// dibpm_checker
// port level checks of the block power meter
// ----------------------------------------------------------------------------
`default_nettype none

module dibpm_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        s_tready,
	input wire logic [dibpm_pkg::OUT_W-1:0] m_tdata,
	input wire logic                        m_tvalid,
	input wire logic                        m_tready
);
	import dibpm_pkg::*;

	localparam logic [LEVEL_W-1:0] FLOOR17 = -LEVEL_W'(FLOOR_DB << LEVEL_FRAC_BITS_DEF);

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed under stall");

	// a new word follows a busy cycle of the level unit
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("word appeared without a closing cycle");

	// rx1 level never above full scale
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[16] || m_tdata[16:0] == '0))
		else $error("rx1 level above 0 dBFS");

	// single receiver reports the floor for rx2
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[52] |-> m_tdata[33:17] == FLOOR17)
		else $error("rx2 level not at floor when single");

endmodule

bind dual_iq_block_power_meter dibpm_checker u_dibpm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tdata  (m_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);

`default_nettype wire
